>>> src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> src/pcap_pkg.sv
`default_nettype none

package pcap_pkg;

    // capability type codes, three bits per slot
    localparam logic [2:0] CAP_MSI   = 3'd0;
    localparam logic [2:0] CAP_MSIX  = 3'd1;
    localparam logic [2:0] CAP_PM    = 3'd2;
    localparam logic [2:0] CAP_PCIE  = 3'd3;
    localparam logic [2:0] CAP_VSEC  = 3'd4;
    localparam logic [2:0] CAP_PASID = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_SLOT_COUNT = 3'd0;
    localparam logic [2:0] REG_SLOT_TYPES = 3'd1;
    localparam logic [2:0] REG_MSI_WIDE   = 3'd2;
    localparam logic [2:0] REG_MSI_MASK   = 3'd3;
    localparam logic [2:0] REG_VSEC_LEN   = 3'd4;

    // layout constants
    localparam logic [11:0] CAP_BASE  = 12'h040;
    localparam logic [11:0] SPACE_END = 12'd255;
    localparam logic [8:0]  PCIE_SIZE = 9'd60;

    // write masks
    localparam logic [15:0] MSI_CTRL_MASK   = 16'hFFFF;
    localparam logic [15:0] MSIX_CTRL_MASK  = 16'hC7FF;
    localparam logic [15:0] PM_CTRL_MASK    = 16'h8103;
    localparam logic [15:0] PASID_CTRL_MASK = 16'h0007;

    // access sizes
    localparam logic [2:0] SZ_WORD  = 3'd2;
    localparam logic [2:0] SZ_DWORD = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_ACCESS = 3'b100
    } state_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [3:0]  slot_count;
        logic [23:0] slot_types;
        logic        msi_wide;
        logic        msi_masking;
        logic [7:0]  vsec_len;
    } cfg_t;

    // matched access handed to the slot register file
    typedef struct packed {
        logic        fire;
        logic        is_write;
        logic [2:0]  cap_type;
        logic [7:0]  offset;
        logic [2:0]  size;
        logic [31:0] wdata;
    } acc_t;

endpackage

`default_nettype wire

>>> src/pcap_cfg_regs.sv
`default_nettype none

module pcap_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output pcap_pkg::cfg_t    cfg
);

    logic          wr_en;
    logic [2:0]    reg_idx;
    pcap_pkg::cfg_t cfg_reg;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                pcap_pkg::REG_SLOT_COUNT: cfg_reg.slot_count  <= pwdata[3:0];
                pcap_pkg::REG_SLOT_TYPES: cfg_reg.slot_types  <= pwdata[23:0];
                pcap_pkg::REG_MSI_WIDE:   cfg_reg.msi_wide    <= pwdata[0];
                pcap_pkg::REG_MSI_MASK:   cfg_reg.msi_masking <= pwdata[0];
                pcap_pkg::REG_VSEC_LEN:   cfg_reg.vsec_len    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            pcap_pkg::REG_SLOT_COUNT: prdata = {28'd0, cfg_reg.slot_count};
            pcap_pkg::REG_SLOT_TYPES: prdata = {8'd0, cfg_reg.slot_types};
            pcap_pkg::REG_MSI_WIDE:   prdata = {31'd0, cfg_reg.msi_wide};
            pcap_pkg::REG_MSI_MASK:   prdata = {31'd0, cfg_reg.msi_masking};
            pcap_pkg::REG_VSEC_LEN:   prdata = {24'd0, cfg_reg.vsec_len};
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/pcap_regfile.sv
`default_nettype none

module pcap_regfile #(
    parameter int MAX_SLOTS = 8,
    parameter int IDX_W     = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pcap_pkg::cfg_t   cfg,
    input  wire pcap_pkg::acc_t   acc,
    input  wire logic [IDX_W-1:0] slot,
    output logic                  rd_hit,
    output logic [31:0]           rd_data
);

    logic [15:0] ctrl_reg     [MAX_SLOTS];
    logic [31:0] addr_lo_reg  [MAX_SLOTS];
    logic [31:0] addr_hi_reg  [MAX_SLOTS];
    logic [15:0] msg_data_reg [MAX_SLOTS];
    logic [31:0] vmask_reg    [MAX_SLOTS];

    logic [7:0]  data_off;
    logic [7:0]  mask_off;
    logic        is_msi;
    logic        sz_w;
    logic        sz_d;
    logic        we_ctrl;
    logic        we_lo;
    logic        we_hi;
    logic        we_data;
    logic        we_mask;
    logic [15:0] ctrl_mask;

    assign data_off = cfg.msi_wide ? 8'd12 : 8'd8;
    assign mask_off = cfg.msi_wide ? 8'd16 : 8'd12;
    assign is_msi   = (acc.cap_type == pcap_pkg::CAP_MSI);
    assign sz_w     = (acc.size == pcap_pkg::SZ_WORD);
    assign sz_d     = (acc.size == pcap_pkg::SZ_DWORD);

    // write decode, msi registers in priority order
    always_comb
    begin
        we_ctrl   = 1'b0;
        we_lo     = 1'b0;
        we_hi     = 1'b0;
        we_data   = 1'b0;
        we_mask   = 1'b0;
        ctrl_mask = pcap_pkg::MSI_CTRL_MASK;
        if (acc.fire && acc.is_write)
        begin
            case (acc.cap_type)
                pcap_pkg::CAP_MSI:
                begin
                    if (acc.offset == 8'd2 && sz_w)
                        we_ctrl = 1'b1;
                    else if (acc.offset == 8'd4 && sz_d)
                        we_lo = 1'b1;
                    else if (cfg.msi_wide && acc.offset == 8'd8 && sz_d)
                        we_hi = 1'b1;
                    else if (acc.offset == data_off && sz_w)
                        we_data = 1'b1;
                    else if (cfg.msi_masking && acc.offset == mask_off && sz_d)
                        we_mask = 1'b1;
                end
                pcap_pkg::CAP_MSIX:
                begin
                    ctrl_mask = pcap_pkg::MSIX_CTRL_MASK;
                    we_ctrl   = (acc.offset == 8'd2) && sz_w;
                end
                pcap_pkg::CAP_PM:
                begin
                    ctrl_mask = pcap_pkg::PM_CTRL_MASK;
                    we_ctrl   = (acc.offset == 8'd4) && sz_w;
                end
                pcap_pkg::CAP_PASID:
                begin
                    ctrl_mask = pcap_pkg::PASID_CTRL_MASK;
                    we_ctrl   = (acc.offset == 8'd4) && sz_w;
                end
                default: ;
            endcase
        end
    end

    // per-slot register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                ctrl_reg[i]     <= '0;
                addr_lo_reg[i]  <= '0;
                addr_hi_reg[i]  <= '0;
                msg_data_reg[i] <= '0;
                vmask_reg[i]    <= '0;
            end
        end
        else
        begin
            if (we_ctrl)
                ctrl_reg[slot] <= acc.wdata[15:0] & ctrl_mask;
            if (we_lo)
                addr_lo_reg[slot] <= acc.wdata;
            if (we_hi)
                addr_hi_reg[slot] <= acc.wdata;
            if (we_data)
                msg_data_reg[slot] <= acc.wdata[15:0];
            if (we_mask)
                vmask_reg[slot] <= acc.wdata;
        end
    end

    // read decode; msi data, address and mask ignore the access size
    always_comb
    begin
        rd_hit  = 1'b0;
        rd_data = 32'd0;
        case (acc.cap_type) inside
            pcap_pkg::CAP_MSI:
            begin
                if (acc.offset == 8'd2 && sz_w)
                begin
                    rd_hit  = 1'b1;
                    rd_data = {16'd0, ctrl_reg[slot]};
                end
                else if (acc.offset == 8'd4)
                begin
                    rd_hit  = 1'b1;
                    rd_data = addr_lo_reg[slot];
                end
                else if (cfg.msi_wide && acc.offset == 8'd8)
                begin
                    rd_hit  = 1'b1;
                    rd_data = addr_hi_reg[slot];
                end
                else if (acc.offset == data_off)
                begin
                    rd_hit  = 1'b1;
                    rd_data = {16'd0, msg_data_reg[slot]};
                end
                else if (cfg.msi_masking && acc.offset == mask_off)
                begin
                    rd_hit  = 1'b1;
                    rd_data = vmask_reg[slot];
                end
            end
            pcap_pkg::CAP_MSIX:
            begin
                rd_hit  = (acc.offset == 8'd2) && sz_w;
                rd_data = {16'd0, ctrl_reg[slot]};
            end
            pcap_pkg::CAP_PM, pcap_pkg::CAP_PASID:
            begin
                rd_hit  = (acc.offset == 8'd4) && sz_w;
                rd_data = {16'd0, ctrl_reg[slot]};
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> src/pcap_walker.sv
`default_nettype none

`include "assert_macros.svh"

module pcap_walker #(
    parameter int MAX_SLOTS = 8,
    parameter int IDX_W     = 3,
    parameter int CNT_W     = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pcap_pkg::cfg_t   cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             cmd,
    input  wire logic [7:0]       byte_address,
    input  wire logic [2:0]       access_bytes,
    input  wire logic [31:0]      write_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  handled,
    output logic [31:0]           read_data,
    output pcap_pkg::acc_t        acc,
    output logic [IDX_W-1:0]      slot,
    input  wire logic             rd_hit,
    input  wire logic [31:0]      rd_data
);

    localparam logic [3:0] MAX_SLOTS_CFG = 4'(MAX_SLOTS);

    pcap_pkg::state_t state_reg, state_next;

    logic             is_write_reg;
    logic [7:0]       addr_reg;
    logic [2:0]       size_reg;
    logic [31:0]      wdata_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] count_reg;
    logic [11:0]      base_reg;
    logic             found_reg;
    logic [2:0]       type_reg;
    logic [7:0]       off_reg;
    logic             out_valid_reg;
    logic             handled_reg;
    logic [31:0]      read_data_reg;

    logic [CNT_W-1:0] count_next;
    logic [2:0]       cur_type;
    logic [8:0]       cur_size;
    logic [11:0]      slot_end;
    logic             slot_match;
    logic             walk_done;
    logic             load;

    // slot count clamp, taken at accept
    assign count_next = (cfg.slot_count > MAX_SLOTS_CFG) ? CNT_W'(MAX_SLOTS)
                                                         : CNT_W'(cfg.slot_count);

    // shared size, add and range compare for the current slot
    assign cur_type = cfg.slot_types[32'(cnt_reg[IDX_W-1:0]) * 3 +: 3];

    always_comb
    begin
        case (cur_type)
            pcap_pkg::CAP_MSI:
                cur_size = 9'd12 + (cfg.msi_wide ? 9'd4 : 9'd0)
                                 + (cfg.msi_masking ? 9'd8 : 9'd0);
            pcap_pkg::CAP_MSIX:  cur_size = 9'd12;
            pcap_pkg::CAP_PM:    cur_size = 9'd8;
            pcap_pkg::CAP_PCIE:  cur_size = pcap_pkg::PCIE_SIZE;
            pcap_pkg::CAP_VSEC:  cur_size = 9'd8 + {1'b0, cfg.vsec_len};
            pcap_pkg::CAP_PASID: cur_size = 9'd8;
            default:             cur_size = 9'd0;
        endcase
    end

    assign slot_end   = base_reg + {3'd0, cur_size};
    assign slot_match = (base_reg <= pcap_pkg::SPACE_END)
                     && ({4'd0, addr_reg} >= base_reg)
                     && ({4'd0, addr_reg} < slot_end);
    assign walk_done  = (cnt_reg == count_reg);

    // result register load when the output side is free
    assign load = (state_reg == pcap_pkg::ST_ACCESS) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcap_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pcap_pkg::ST_WALK;
            pcap_pkg::ST_WALK:
                if (walk_done || slot_match)
                    state_next = pcap_pkg::ST_ACCESS;
            pcap_pkg::ST_ACCESS:
                if (load)
                    state_next = pcap_pkg::ST_IDLE;
            default:
                state_next = pcap_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcap_pkg::ST_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            base_reg      <= pcap_pkg::CAP_BASE;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // start of a walk
            if (state_reg == pcap_pkg::ST_IDLE && in_valid)
            begin
                cnt_reg   <= '0;
                count_reg <= count_next;
                base_reg  <= pcap_pkg::CAP_BASE;
                found_reg <= 1'b0;
            end
            // one slot per cycle
            else if (state_reg == pcap_pkg::ST_WALK && !walk_done)
            begin
                if (slot_match)
                    found_reg <= 1'b1;
                else
                begin
                    base_reg <= slot_end;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
            end
            // output register handshake
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == pcap_pkg::ST_IDLE && in_valid)
        begin
            is_write_reg <= cmd;
            addr_reg     <= byte_address;
            size_reg     <= access_bytes;
            wdata_reg    <= write_data;
        end
        if (state_reg == pcap_pkg::ST_WALK && !walk_done && slot_match)
        begin
            type_reg <= cur_type;
            off_reg  <= addr_reg - base_reg[7:0];
        end
        if (load)
        begin
            handled_reg   <= found_reg && (is_write_reg || rd_hit);
            read_data_reg <= (found_reg && !is_write_reg && rd_hit) ? rd_data : 32'd0;
        end
    end

    // access toward the slot registers
    always_comb
    begin
        acc.fire     = load && found_reg;
        acc.is_write = is_write_reg;
        acc.cap_type = type_reg;
        acc.offset   = off_reg;
        acc.size     = size_reg;
        acc.wdata    = wdata_reg;
    end

    assign slot      = cnt_reg[IDX_W-1:0];
    assign in_ready  = (state_reg == pcap_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign handled   = handled_reg;
    assign read_data = read_data_reg;

    `ASSERT_IMPLIES(a_walk_bound, clk, rst_n, state_reg == pcap_pkg::ST_WALK, cnt_reg <= count_reg, "slot counter ran past the slot count")
    `ASSERT_IMPLIES(a_hit_in_space, clk, rst_n, state_reg == pcap_pkg::ST_ACCESS && found_reg, base_reg <= pcap_pkg::SPACE_END && cnt_reg < count_reg, "matched slot lies outside the space")
    `ASSERT_NEXT(a_accept_walks, clk, rst_n, in_valid && in_ready, state_reg == pcap_pkg::ST_WALK && !out_valid_reg == !$past(out_valid_reg && !out_ready), "accepted transfer did not start a walk")
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, state_reg == pcap_pkg::ST_ACCESS && out_valid_reg && !out_ready, state_reg == pcap_pkg::ST_ACCESS && $stable(read_data_reg) && $stable(handled_reg), "pending result overwritten under stall")
    `ASSERT_NEXT(a_write_handled, clk, rst_n, load && found_reg && is_write_reg, out_valid_reg && handled_reg, "write inside a slot not reported handled")

endmodule

`default_nettype wire

>>> src/pci_capability_register_access.sv
// pci capability register access
// configuration: apb-style port, pready always high, registers at byte
// address 4*i: slot_count, slot_types, msi_wide_address,
// msi_vector_masking, vendor_section_length. writes land on the access
// phase; configure only while no transfer is in flight.
// input channel: in_valid/in_ready carry cmd, byte_address, access_bytes
// and write_data; one result transfer (handled, read_data) per input.
// walk: the sequencer walks the slot list one slot per cycle from
// offset 0x40 through a single size/add/compare unit, then decodes the
// matched slot's registers in the access step. in_ready is low from
// accept until the result is loaded.
// the result sits in an output register: a new input is taken while it
// waits, but a stalled out_ready holds the next result in the decode step.
// reset clears the configuration, all slot registers and the sequencer.
`default_nettype none

module pci_capability_register_access #(
    parameter int MAX_SLOTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [7:0]  byte_address,
    input  wire logic [2:0]  access_bytes,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             handled,
    output logic [31:0]      read_data
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    pcap_pkg::cfg_t   cfg;
    pcap_pkg::acc_t   acc;
    logic [IDX_W-1:0] slot;
    logic             rd_hit;
    logic [31:0]      rd_data;

    assign pready = 1'b1;

    // configuration registers
    pcap_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // slot walk sequencer
    pcap_walker #(
        .MAX_SLOTS (MAX_SLOTS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .byte_address (byte_address),
        .access_bytes (access_bytes),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .handled      (handled),
        .read_data    (read_data),
        .acc          (acc),
        .slot         (slot),
        .rd_hit       (rd_hit),
        .rd_data      (rd_data)
    );

    // per-slot capability registers
    pcap_regfile #(
        .MAX_SLOTS (MAX_SLOTS),
        .IDX_W     (IDX_W)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .acc     (acc),
        .slot    (slot),
        .rd_hit  (rd_hit),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> dv/pcap_access_checker.sv
`timescale 1ns / 1ps

module pcap_access_checker #(
    parameter int MAX_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  byte_address,
    input  logic [2:0]  access_bytes,
    input  logic [31:0] write_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        handled,
    input  logic [31:0] read_data,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic        handled;
        logic [31:0] read_data;
    } access_result_t;

    // configuration as written over the register port
    logic [3:0]  slot_count_q;
    logic [23:0] slot_types_q;
    logic        wide_q;
    logic        masking_q;
    logic [7:0]  vsec_len_q;

    // per-slot register copies
    logic [15:0] ctrl_word [MAX_SLOTS];
    logic [31:0] addr_low  [MAX_SLOTS];
    logic [31:0] addr_high [MAX_SLOTS];
    logic [15:0] msg_data  [MAX_SLOTS];
    logic [31:0] vec_mask  [MAX_SLOTS];

    access_result_t expected_results[$];
    access_result_t oldest;
    int             i;

    // bytes occupied by a capability of the given kind
    function automatic int slot_span(logic [2:0] kind);
        case (kind)
            pcap_pkg::CAP_MSI:   return 12 + (wide_q ? 4 : 0) + (masking_q ? 8 : 0);
            pcap_pkg::CAP_MSIX:  return 12;
            pcap_pkg::CAP_PM:    return 8;
            pcap_pkg::CAP_PCIE:  return int'(pcap_pkg::PCIE_SIZE);
            pcap_pkg::CAP_VSEC:  return 8 + int'(vsec_len_q);
            pcap_pkg::CAP_PASID: return 8;
            default:             return 0;
        endcase
    endfunction

    // walk the slot chain, apply a write or look up a read
    function automatic access_result_t serve_access(logic is_write, logic [7:0] addr,
                                                    logic [2:0] size, logic [31:0] wdata);
        access_result_t res;
        int             count;
        int             base;
        int             span;
        int             off;
        int             data_off;
        int             mask_off;
        logic [2:0]     kind;
        logic           matched;
        res      = '0;
        matched  = 1'b0;
        base     = int'(pcap_pkg::CAP_BASE);
        count    = (slot_count_q > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count_q);
        data_off = wide_q ? 12 : 8;
        mask_off = wide_q ? 16 : 12;
        for (int s = 0; s < count; s++)
        begin
            if (!matched)
            begin
                kind = slot_types_q[3*s +: 3];
                span = slot_span(kind);
                if (base <= int'(pcap_pkg::SPACE_END) && int'(addr) >= base
                    && int'(addr) < base + span)
                begin
                    matched = 1'b1;
                    off = int'(addr) - base;
                    if (is_write)
                    begin
                        res.handled = 1'b1;
                        case (kind)
                            pcap_pkg::CAP_MSI:
                            begin
                                if (off == 2 && size == pcap_pkg::SZ_WORD)
                                    ctrl_word[s] = wdata[15:0] & pcap_pkg::MSI_CTRL_MASK;
                                else if (off == 4 && size == pcap_pkg::SZ_DWORD)
                                    addr_low[s] = wdata;
                                else if (wide_q && off == 8 && size == pcap_pkg::SZ_DWORD)
                                    addr_high[s] = wdata;
                                else if (off == data_off && size == pcap_pkg::SZ_WORD)
                                    msg_data[s] = wdata[15:0];
                                else if (masking_q && off == mask_off
                                         && size == pcap_pkg::SZ_DWORD)
                                    vec_mask[s] = wdata;
                            end
                            pcap_pkg::CAP_MSIX:
                                if (off == 2 && size == pcap_pkg::SZ_WORD)
                                    ctrl_word[s] = wdata[15:0] & pcap_pkg::MSIX_CTRL_MASK;
                            pcap_pkg::CAP_PM:
                                if (off == 4 && size == pcap_pkg::SZ_WORD)
                                    ctrl_word[s] = wdata[15:0] & pcap_pkg::PM_CTRL_MASK;
                            pcap_pkg::CAP_PASID:
                                if (off == 4 && size == pcap_pkg::SZ_WORD)
                                    ctrl_word[s] = wdata[15:0] & pcap_pkg::PASID_CTRL_MASK;
                            default: ;
                        endcase
                    end
                    else
                    begin
                        case (kind) inside
                            pcap_pkg::CAP_MSI:
                            begin
                                res.handled = 1'b1;
                                if (off == 2 && size == pcap_pkg::SZ_WORD)
                                    res.read_data = {16'h0, ctrl_word[s]};
                                else if (off == 4)
                                    res.read_data = addr_low[s];
                                else if (wide_q && off == 8)
                                    res.read_data = addr_high[s];
                                else if (off == data_off)
                                    res.read_data = {16'h0, msg_data[s]};
                                else if (masking_q && off == mask_off)
                                    res.read_data = vec_mask[s];
                                else
                                    res.handled = 1'b0;
                            end
                            pcap_pkg::CAP_MSIX:
                                if (off == 2 && size == pcap_pkg::SZ_WORD)
                                    res = {1'b1, 16'h0, ctrl_word[s]};
                            pcap_pkg::CAP_PM, pcap_pkg::CAP_PASID:
                                if (off == 4 && size == pcap_pkg::SZ_WORD)
                                    res = {1'b1, 16'h0, ctrl_word[s]};
                            default: ;
                        endcase
                    end
                end
                base += span;
            end
        end
        return res;
    endfunction

    // result compare, access prediction and register tracking
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_q = '0;
            slot_types_q = '0;
            wide_q       = 1'b0;
            masking_q    = 1'b0;
            vsec_len_q   = '0;
            for (i = 0; i < MAX_SLOTS; i++)
            begin
                ctrl_word[i] = '0;
                addr_low[i]  = '0;
                addr_high[i] = '0;
                msg_data[i]  = '0;
                vec_mask[i]  = '0;
            end
            expected_results.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            // result transfer against the oldest outstanding access
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no access outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (handled !== oldest.handled)
                    begin
                        $error("handled: expected %0d, actual %0d", oldest.handled, handled);
                        fail_count++;
                    end
                    if (read_data !== oldest.read_data)
                    begin
                        $error("read_data: expected 0x%08h, actual 0x%08h",
                               oldest.read_data, read_data);
                        fail_count++;
                    end
                end
            end
            // access transfer
            if (in_valid && in_ready)
                expected_results.push_back(serve_access(cmd, byte_address, access_bytes,
                                                        write_data));
            // register write on the access phase
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    pcap_pkg::REG_SLOT_COUNT: slot_count_q = pwdata[3:0];
                    pcap_pkg::REG_SLOT_TYPES: slot_types_q = pwdata[23:0];
                    pcap_pkg::REG_MSI_WIDE:   wide_q       = pwdata[0];
                    pcap_pkg::REG_MSI_MASK:   masking_q    = pwdata[0];
                    pcap_pkg::REG_VSEC_LEN:   vsec_len_q   = pwdata[7:0];
                    default: ;
                endcase
            end
            pending_count = expected_results.size();
        end
    end

endmodule

>>> dv/tb_pci_capability_register_access.sv
`timescale 1ns / 1ps

module tb_pci_capability_register_access;

    localparam int         MAX_SLOTS    = 8;
    localparam logic [2:0] CAP_RESERVED = 3'd6;
    localparam int         HOLD_AT      = 400;
    localparam int         HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;
    logic        in_valid;
    wire         in_ready;
    logic        cmd;
    logic [7:0]  byte_address;
    logic [2:0]  access_bytes;
    logic [31:0] write_data;
    wire         out_valid;
    logic        out_ready;
    wire         handled;
    wire  [31:0] read_data;
    int          fail_count;
    int          pending_count;

    // settings currently loaded, used to aim accesses at live slots
    logic [3:0]  cur_count;
    logic [23:0] cur_types;
    logic        cur_wide;
    logic        cur_masking;
    logic [7:0]  cur_vlen;
    logic        sender_burst;

    pci_capability_register_access #(.MAX_SLOTS(MAX_SLOTS)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .byte_address (byte_address),
        .access_bytes (access_bytes),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .handled      (handled),
        .read_data    (read_data)
    );

    pcap_access_checker #(.MAX_SLOTS(MAX_SLOTS)) access_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .byte_address  (byte_address),
        .access_bytes  (access_bytes),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .handled       (handled),
        .read_data     (read_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // register write: setup cycle, then access cycle; the caller ends the burst
    task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [3:0] count, input logic [23:0] types,
                              input logic wide, input logic masking, input logic [7:0] vlen);
        cur_count   = count;
        cur_types   = types;
        cur_wide    = wide;
        cur_masking = masking;
        cur_vlen    = vlen;
        apb_write(pcap_pkg::REG_SLOT_COUNT, 32'(count));
        apb_write(pcap_pkg::REG_SLOT_TYPES, 32'(types));
        apb_write(pcap_pkg::REG_MSI_WIDE, 32'(wide));
        apb_write(pcap_pkg::REG_MSI_MASK, 32'(masking));
        apb_write(pcap_pkg::REG_VSEC_LEN, 32'(vlen));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one access transfer, called and returning at a falling edge
    task automatic send_access(input logic is_write, input logic [7:0] addr,
                               input logic [2:0] size, input logic [31:0] data);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd          <= is_write;
        byte_address <= addr;
        access_bytes <= size;
        write_data   <= data;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // stop offering and let every result come back
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    function automatic int cap_bytes(logic [2:0] kind);
        case (kind)
            pcap_pkg::CAP_MSI:   return 12 + (cur_wide ? 4 : 0) + (cur_masking ? 8 : 0);
            pcap_pkg::CAP_MSIX:  return 12;
            pcap_pkg::CAP_PM:    return 8;
            pcap_pkg::CAP_PCIE:  return int'(pcap_pkg::PCIE_SIZE);
            pcap_pkg::CAP_VSEC:  return 8 + int'(cur_vlen);
            pcap_pkg::CAP_PASID: return 8;
            default:             return 0;
        endcase
    endfunction

    // mostly register offsets of a reachable slot, sometimes anywhere
    task automatic pick_access(output logic [7:0] addr, output logic [2:0] size);
        int bases[MAX_SLOTS];
        int spans[MAX_SLOTS];
        int live[$];
        int base;
        int eff;
        int s;
        int off;
        int k;
        base = int'(pcap_pkg::CAP_BASE);
        eff  = (cur_count > MAX_SLOTS) ? MAX_SLOTS : int'(cur_count);
        for (s = 0; s < eff; s++)
        begin
            spans[s] = cap_bytes(cur_types[3*s +: 3]);
            bases[s] = base;
            if (base <= int'(pcap_pkg::SPACE_END) && spans[s] > 0)
                live.push_back(s);
            base += spans[s];
        end
        if (live.size() > 0 && $urandom_range(0, 9) < 8)
        begin
            s = live[$urandom_range(0, live.size() - 1)];
            case ($urandom_range(0, 5))
                0:       off = 2;
                1:       off = 4;
                2:       off = 8;
                3:       off = 12;
                4:       off = 16;
                default: off = $urandom_range(0, spans[s] - 1);
            endcase
            addr = 8'(bases[s] + off);
        end
        else
        begin
            addr = 8'($urandom_range(0, 255));
        end
        k = $urandom_range(0, 9);
        if (k < 4)
            size = pcap_pkg::SZ_WORD;
        else if (k < 7)
            size = pcap_pkg::SZ_DWORD;
        else
            size = 3'($urandom_range(0, 7));
    endtask

    function automatic logic [23:0] random_types();
        logic [23:0] types;
        int          k;
        for (int s = 0; s < MAX_SLOTS; s++)
        begin
            k = $urandom_range(0, 15);
            types[3*s +: 3] = (k < 14) ? 3'(k % 6) : 3'(k - 8);
        end
        return types;
    endfunction

    // result side: random stalls, one long hold to back up the input
    initial
    begin
        int stall;
        int taken;
        logic burst;
        out_ready = 1'b0;
        taken = 0;
        burst = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, 15);
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            taken++;
        end
    end

    // stimulus
    initial
    begin
        logic [7:0]  addr;
        logic [2:0]  size;
        logic [31:0] data;
        logic [3:0]  count;
        int          n;
        int          quota;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        cmd          = 1'b0;
        byte_address = '0;
        access_bytes = '0;
        write_data   = '0;
        sender_burst = 1'b0;
        cur_count    = '0;
        cur_types    = '0;
        cur_wide     = 1'b0;
        cur_masking  = 1'b0;
        cur_vlen     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: no slots, every access misses
        for (n = 0; n < 10; n++)
            send_access(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        3'($urandom_range(0, 7)), $urandom);
        drain();

        // directed: a slot of each kind (msi twice), vendor slot runs to the end of the space,
        // the pcie slot then starts past it and the reserved slot takes no bytes
        set_config(4'd8, {pcap_pkg::CAP_MSI, CAP_RESERVED, pcap_pkg::CAP_PCIE,
                          pcap_pkg::CAP_VSEC, pcap_pkg::CAP_PASID, pcap_pkg::CAP_PM,
                          pcap_pkg::CAP_MSIX, pcap_pkg::CAP_MSI},
                   1'b1, 1'b1, 8'd247);
        send_access(1'b1, 8'h42, pcap_pkg::SZ_WORD, 32'hFFFF_FFFF);
        send_access(1'b0, 8'h42, pcap_pkg::SZ_WORD, 32'h0);
        send_access(1'b1, 8'h44, pcap_pkg::SZ_DWORD, 32'hFFFF_FFFF);
        send_access(1'b1, 8'h48, pcap_pkg::SZ_DWORD, 32'hA5A5_5A5A);
        send_access(1'b1, 8'h4C, pcap_pkg::SZ_WORD, 32'hFFFF_1234);
        send_access(1'b1, 8'h50, pcap_pkg::SZ_DWORD, 32'hFFFF_FFFF);
        // address, data and mask reads ignore the size
        send_access(1'b0, 8'h44, 3'd1, 32'h0);
        send_access(1'b0, 8'h48, 3'd7, 32'h0);
        send_access(1'b0, 8'h4C, 3'd0, 32'h0);
        send_access(1'b0, 8'h50, pcap_pkg::SZ_DWORD, 32'h0);
        // unmatched offset or size inside a slot
        send_access(1'b1, 8'h41, 3'd1, 32'h0000_DEAD);
        send_access(1'b1, 8'h42, pcap_pkg::SZ_DWORD, 32'h0);
        send_access(1'b0, 8'h42, pcap_pkg::SZ_DWORD, 32'h0);
        // masked control registers
        send_access(1'b1, 8'h5A, pcap_pkg::SZ_WORD, 32'hFFFF_FFFF);
        send_access(1'b0, 8'h5A, pcap_pkg::SZ_WORD, 32'h0);
        send_access(1'b1, 8'h68, pcap_pkg::SZ_WORD, 32'hFFFF_FFFF);
        send_access(1'b0, 8'h68, pcap_pkg::SZ_WORD, 32'h0);
        send_access(1'b1, 8'h70, pcap_pkg::SZ_WORD, 32'hFFFF_FFFF);
        send_access(1'b0, 8'h70, pcap_pkg::SZ_WORD, 32'h0);
        send_access(1'b0, 8'h68, 3'd1, 32'h0);
        // vendor slot at its start and at the end of the space, then outside every slot
        send_access(1'b0, 8'h74, pcap_pkg::SZ_WORD, 32'h0);
        send_access(1'b1, 8'hFF, pcap_pkg::SZ_DWORD, 32'hFFFF_FFFF);
        send_access(1'b0, 8'h00, pcap_pkg::SZ_DWORD, 32'h0);
        send_access(1'b1, 8'h3F, pcap_pkg::SZ_WORD, 32'hFFFF_FFFF);
        drain();

        // random phases over several settings
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(4'd8, 24'h000000, 1'b1, 1'b1, 8'd0);
                1: set_config(4'd15, random_types(), 1'b0, 1'b0, 8'd247);
                2: set_config(4'd4, random_types(), 1'b1, 1'b0, 8'd0);
                3: set_config(4'd0, 24'hFFFFFF, 1'b0, 1'b1, 8'd247);
                default:
                begin
                    count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                        : 4'($urandom_range(1, 8));
                    set_config(count, random_types(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 8'($urandom_range(0, 247)));
                end
            endcase
            quota = (p == 3) ? 40 : 250;
            n = 0;
            while (n < quota)
            begin
                pick_access(addr, size);
                data = $urandom;
                if ($urandom_range(0, 2) == 0)
                begin
                    // write followed by a read back of the same register
                    send_access(1'b1, addr, size, data);
                    send_access(1'b0, addr, size, $urandom);
                    n += 2;
                end
                else
                begin
                    send_access(1'($urandom_range(0, 1)), addr, size, data);
                    n++;
                end
                if ($urandom_range(0, 39) == 0)
                    sender_burst = !sender_burst;
            end
            drain();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
